@@ hdl/vfd_pkg.sv @@
`timescale 1ns / 1ps
package vfd_pkg;

    localparam logic [7:0] HEADER_BYTE  = 8'hAA;
    localparam logic [7:0] TAIL_BYTE    = 8'h55;
    localparam logic [3:0] POS_HUNT     = 4'd0;
    localparam logic [3:0] POS_TAIL     = 4'd13;
    localparam int         PAYLOAD_BITS = 96;
    localparam int         MAG_W        = 31;
    localparam int         GAIN_W       = 24;
    localparam int         DB_W         = 16;
    localparam int         DRV_W        = 16;
    localparam int         PROD_W       = MAG_W + GAIN_W;
    localparam int         PROD_SHIFT   = 17;
    localparam int         SPROD_W      = PROD_W - PROD_SHIFT;
    localparam int         QUEUE_DEPTH  = 2;
    localparam int         LANES        = 3;

    localparam logic [7:0]       EXP_ALL_ONES = 8'hFF;
    localparam logic [7:0]       EXP_ZERO     = 8'h00;
    localparam logic [7:0]       EXP_SAT      = 8'd142;
    localparam logic [7:0]       EXP_UNIT     = 8'd134;
    localparam logic [7:0]       EXP_MIN      = 8'd103;
    localparam logic [MAG_W-1:0] MAG_MAX      = {MAG_W{1'b1}};

    typedef logic [PAYLOAD_BITS-1:0] frame_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_status_t;

    typedef struct packed {
        logic [GAIN_W-1:0] gain_lateral;
        logic [GAIN_W-1:0] gain_forward;
        logic [GAIN_W-1:0] gain_turn;
        logic [DB_W-1:0]   deadband;
    } cfg_t;

    typedef enum logic [1:0] {
        REG_GAIN_LATERAL = 2'd0,
        REG_GAIN_FORWARD = 2'd1,
        REG_GAIN_TURN    = 2'd2,
        REG_DEADBAND     = 2'd3
    } reg_index_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_MUL,
        BK_CLAMP,
        BK_DONE
    } back_state_t;

endpackage

@@ hdl/vfd_front.sv @@
`timescale 1ns / 1ps
module vfd_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         rx_byte,
    output logic               push,
    output vfd_pkg::frame_t    push_frame,
    input  vfd_pkg::q_status_t q_stat
);
    import vfd_pkg::*;

    logic [3:0] pos_reg;
    logic [3:0] pos_next;
    frame_t     payload_reg;
    logic       accept;
    logic       at_tail;

    assign at_tail    = (pos_reg >= POS_TAIL);
    assign in_stall   = q_stat.full && at_tail;
    assign accept     = in_valid && !in_stall;
    assign push       = accept && at_tail && (rx_byte == TAIL_BYTE);
    assign push_frame = payload_reg;

    always_comb
    begin
        pos_next = pos_reg;
        if (accept)
        begin
            if (pos_reg == POS_HUNT)
            begin
                if (rx_byte == HEADER_BYTE)
                begin
                    pos_next = 4'd1;
                end
            end
            else if (at_tail)
            begin
                pos_next = POS_HUNT;
            end
            else
            begin
                pos_next = pos_reg + 4'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= POS_HUNT;
        end
        else
        begin
            pos_reg <= pos_next;
        end
    end

    // Payload bytes shift in from the top, so the first byte ends up lowest.
    always_ff @(posedge clk)
    begin
        if (accept && (pos_reg != POS_HUNT) && !at_tail)
        begin
            payload_reg <= {rx_byte, payload_reg[PAYLOAD_BITS-1:8]};
        end
    end

endmodule

@@ hdl/vfd_queue.sv @@
`timescale 1ns / 1ps
module vfd_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  vfd_pkg::frame_t    push_frame,
    input  logic               pop,
    output vfd_pkg::frame_t    head,
    output vfd_pkg::q_status_t q_stat
);
    import vfd_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    frame_t           entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign q_stat.empty = (count_reg == '0);
    assign q_stat.full  = (count_reg == CNT_FULL);
    assign do_push      = push && !q_stat.full;
    assign do_pop       = pop && !q_stat.empty;
    assign head         = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_frame;
        end
    end

endmodule

@@ hdl/vfd_back.sv @@
`timescale 1ns / 1ps
module vfd_back (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  vfd_pkg::cfg_t                        cfg,
    input  vfd_pkg::q_status_t                   q_stat,
    input  vfd_pkg::frame_t                      head,
    output logic                                 pop,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [vfd_pkg::DRV_W-1:0]     joy_x,
    output logic signed [vfd_pkg::DRV_W-1:0]     joy_y,
    output logic signed [vfd_pkg::DRV_W-1:0]     turn_rate,
    output logic                                 stop
);
    import vfd_pkg::*;

    // Returns the sign in the top bit and the truncated, saturated Q15.16
    // magnitude below it.
    function automatic logic [MAG_W:0] float_to_q16(input logic [31:0] bits);
        logic [7:0]       expo;
        logic [22:0]      frac;
        logic [MAG_W-1:0] man;
        logic [2:0]       sh_l;
        logic [4:0]       sh_r;
        logic             sgn;
        logic [MAG_W-1:0] mag;
        expo = bits[30:23];
        frac = bits[22:0];
        sgn  = bits[31];
        man  = MAG_W'({1'b1, frac});
        sh_l = 3'(expo - EXP_UNIT);
        sh_r = 5'(EXP_UNIT - expo);
        if (expo == EXP_ALL_ONES)
        begin
            if (frac != '0)
            begin
                sgn = 1'b0;
                mag = '0;
            end
            else
            begin
                mag = MAG_MAX;
            end
        end
        else if (expo == EXP_ZERO)
        begin
            mag = '0;
        end
        else if (expo >= EXP_SAT)
        begin
            mag = MAG_MAX;
        end
        else if (expo >= EXP_UNIT)
        begin
            mag = man << sh_l;
        end
        else if (expo >= EXP_MIN)
        begin
            mag = man >> sh_r;
        end
        else
        begin
            mag = '0;
        end
        return {sgn, mag};
    endfunction

    function automatic logic [DRV_W-1:0] clamp_drive(input logic [SPROD_W-1:0] p,
                                                     input logic neg);
        logic [DRV_W-1:0] res;
        if (p == '0)
        begin
            res = '0;
        end
        else if (neg)
        begin
            if (p > SPROD_W'(32768))
            begin
                res = 16'h8000;
            end
            else
            begin
                res = DRV_W'(17'h10000 - p[16:0]);
            end
        end
        else if (p > SPROD_W'(32767))
        begin
            res = 16'h7FFF;
        end
        else
        begin
            res = p[DRV_W-1:0];
        end
        return res;
    endfunction

    back_state_t       state_reg;
    back_state_t       state_next;
    logic [MAG_W-1:0]  mag_reg [LANES];
    logic [LANES-1:0]  neg_reg;
    logic [1:0]        idx_reg;
    logic [1:0]        idx_next;
    logic [SPROD_W-1:0] prod_reg;
    logic              pneg_reg;
    logic [DRV_W-1:0]  drv_reg [LANES];
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [DRV_W-1:0]  joy_x_reg;
    logic [DRV_W-1:0]  joy_y_reg;
    logic [DRV_W-1:0]  turn_reg;
    logic              stop_reg;

    logic [MAG_W:0]    cv_x;
    logic [MAG_W:0]    cv_y;
    logic [MAG_W:0]    cv_z;
    logic [GAIN_W-1:0] gain_sel;
    logic [PROD_W-1:0] prod_full;
    logic [DRV_W-1:0]  drv_val;
    logic              out_free;
    logic              load_out;
    logic              in_deadband;
    logic              last_lane;

    assign cv_x = float_to_q16(head[31:0]);
    assign cv_y = float_to_q16(head[63:32]);
    assign cv_z = float_to_q16(head[95:64]);

    always_comb
    begin
        case (idx_reg)
            2'd0:    gain_sel = cfg.gain_lateral;
            2'd1:    gain_sel = cfg.gain_forward;
            default: gain_sel = cfg.gain_turn;
        endcase
    end

    assign prod_full   = PROD_W'(mag_reg[idx_reg]) * PROD_W'(gain_sel);
    assign drv_val     = clamp_drive(prod_reg, pneg_reg);
    assign out_free    = !out_valid_reg || !out_stall;
    assign last_lane   = (idx_reg == 2'(LANES - 1));
    assign in_deadband = (mag_reg[0] < MAG_W'(cfg.deadband))
                      && (mag_reg[1] < MAG_W'(cfg.deadband))
                      && (mag_reg[2] < MAG_W'(cfg.deadband));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    state_next = BK_MUL;
                end
            end
            BK_MUL:
            begin
                state_next = BK_CLAMP;
            end
            BK_CLAMP:
            begin
                state_next = last_lane ? BK_DONE : BK_MUL;
            end
            BK_DONE:
            begin
                if (out_free)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        pop            = 1'b0;
        load_out       = 1'b0;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg && out_stall;
        unique case (state_reg)
            BK_IDLE:
            begin
                pop      = !q_stat.empty;
                idx_next = 2'd0;
            end
            BK_MUL:
            begin
                idx_next = idx_reg;
            end
            BK_CLAMP:
            begin
                idx_next = last_lane ? idx_reg : idx_reg + 2'd1;
            end
            BK_DONE:
            begin
                load_out = out_free;
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Lanes are kept in output order: lateral from negated vy, forward
    // from vx, turn from wz.
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            mag_reg[0] <= cv_y[MAG_W-1:0];
            mag_reg[1] <= cv_x[MAG_W-1:0];
            mag_reg[2] <= cv_z[MAG_W-1:0];
            neg_reg    <= {cv_z[MAG_W], cv_x[MAG_W], !cv_y[MAG_W]};
        end
        if (state_reg == BK_MUL)
        begin
            prod_reg <= prod_full[PROD_W-1:PROD_SHIFT];
            pneg_reg <= neg_reg[idx_reg];
        end
        if (state_reg == BK_CLAMP)
        begin
            drv_reg[idx_reg] <= drv_val;
        end
        if (load_out)
        begin
            stop_reg  <= in_deadband;
            joy_x_reg <= in_deadband ? '0 : drv_reg[0];
            joy_y_reg <= in_deadband ? '0 : drv_reg[1];
            turn_reg  <= in_deadband ? '0 : drv_reg[2];
        end
    end

    assign out_valid = out_valid_reg;
    assign joy_x     = joy_x_reg;
    assign joy_y     = joy_y_reg;
    assign turn_rate = turn_reg;
    assign stop      = stop_reg;

endmodule

@@ hdl/velocity_frame_deframer_unit.sv @@
`timescale 1ns / 1ps
// Velocity frame deframer. It takes one received serial byte per cycle and
// finds 14-byte frames (header 0xAA, twelve payload bytes, tail 0x55); each
// good frame gives one result with the three clamped Q1.15 drive values or a
// stop flag, and a bad tail drops the frame without a result. The byte side
// accepts a byte every cycle and stalls only on the last byte of a frame while
// two good frames still wait for conversion. Conversion uses one shared 31 by
// 24 bit multiplier that serves the three axes in turn, with a multiply and a
// clamp step per axis; the next frame is taken only after the result is loaded.
module velocity_frame_deframer_unit (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [3:0]                           paddr,
    input  logic [31:0]                          pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [7:0]                           rx_byte,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [vfd_pkg::DRV_W-1:0]     joy_x,
    output logic signed [vfd_pkg::DRV_W-1:0]     joy_y,
    output logic signed [vfd_pkg::DRV_W-1:0]     turn_rate,
    output logic                                 stop
);
    import vfd_pkg::*;

    cfg_t       cfg_reg;
    reg_index_t reg_idx;
    logic       cfg_write;
    logic       push;
    logic       pop;
    frame_t     push_frame;
    frame_t     head;
    q_status_t  q_stat;

    assign pready    = 1'b1;
    assign reg_idx   = reg_index_t'(paddr[3:2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gain_lateral <= GAIN_W'(65536);
            cfg_reg.gain_forward <= GAIN_W'(65536);
            cfg_reg.gain_turn    <= GAIN_W'(65536);
            cfg_reg.deadband     <= DB_W'(66);
        end
        else if (cfg_write)
        begin
            unique case (reg_idx)
                REG_GAIN_LATERAL: cfg_reg.gain_lateral <= pwdata[GAIN_W-1:0];
                REG_GAIN_FORWARD: cfg_reg.gain_forward <= pwdata[GAIN_W-1:0];
                REG_GAIN_TURN:    cfg_reg.gain_turn    <= pwdata[GAIN_W-1:0];
                REG_DEADBAND:     cfg_reg.deadband     <= pwdata[DB_W-1:0];
                default:          cfg_reg              <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_GAIN_LATERAL: prdata = 32'(cfg_reg.gain_lateral);
            REG_GAIN_FORWARD: prdata = 32'(cfg_reg.gain_forward);
            REG_GAIN_TURN:    prdata = 32'(cfg_reg.gain_turn);
            REG_DEADBAND:     prdata = 32'(cfg_reg.deadband);
            default:          prdata = '0;
        endcase
    end

    vfd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .rx_byte    (rx_byte),
        .push       (push),
        .push_frame (push_frame),
        .q_stat     (q_stat)
    );

    vfd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_frame (push_frame),
        .pop        (pop),
        .head       (head),
        .q_stat     (q_stat)
    );

    vfd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_stat    (q_stat),
        .head      (head),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .joy_x     (joy_x),
        .joy_y     (joy_y),
        .turn_rate (turn_rate),
        .stop      (stop)
    );

endmodule
